[hdl/wdpc_pkg.sv]
package wdpc_pkg;

    typedef struct packed {
        logic signed [15:0] est_x;
        logic signed [15:0] est_y;
        logic        [15:0] heading_turn;
        logic signed [15:0] heading_passthru;
        logic        [13:0] dist_left;
        logic        [13:0] dist_right;
        logic        [13:0] dist_front;
        logic        [2:0]  use_mask;
        logic signed [15:0] ref_x;
        logic signed [15:0] ref_y;
        logic        [1:0]  ref_valid;
        logic        [14:0] accept_radius;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic signed [15:0] heading_out;
        logic        [1:0]  x_hits;
        logic        [1:0]  y_hits;
        logic               fell_back;
    } out_word_t;

    typedef struct packed {
        logic [14:0]        field_half_size;
        logic [12:0]        wall_tol;
        logic signed [13:0] left_lateral_offset;
        logic signed [13:0] right_lateral_offset;
        logic signed [13:0] front_forward_offset;
    } cfg_t;

    localparam logic [2:0] REG_FIELD = 3'd0;
    localparam logic [2:0] REG_TOL   = 3'd1;
    localparam logic [2:0] REG_LEFT  = 3'd2;
    localparam logic [2:0] REG_RIGHT = 3'd3;
    localparam logic [2:0] REG_FRONT = 3'd4;

    localparam int TABLE_LEN = 24;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    function automatic logic signed [31:0] atan_turn(input int i);
        logic signed [31:0] r;
        begin
            case (i)
                0: r = 32'sd536870912;  1: r = 32'sd316933406;
                2: r = 32'sd167458907;  3: r = 32'sd85004756;
                4: r = 32'sd42667331;   5: r = 32'sd21354465;
                6: r = 32'sd10679838;   7: r = 32'sd5340245;
                8: r = 32'sd2670163;    9: r = 32'sd1335087;
                10: r = 32'sd667544;    11: r = 32'sd333772;
                12: r = 32'sd166886;    13: r = 32'sd83443;
                14: r = 32'sd41722;     15: r = 32'sd20861;
                16: r = 32'sd10430;     17: r = 32'sd5215;
                18: r = 32'sd2608;      19: r = 32'sd1304;
                20: r = 32'sd652;       21: r = 32'sd326;
                22: r = 32'sd163;       23: r = 32'sd81;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

[hdl/wdpc_cordic.sv]
// Pipelined rotation CORDIC, one iteration per stage, sideband delayed alongside.
module wdpc_cordic #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [15:0]              angle,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     out_valid,
    output logic signed [31:0]       cos_q30,
    output logic signed [31:0]       sin_q30,
    output logic [SIDE_W-1:0]        side_out
);
    import wdpc_pkg::*;

    localparam int N = (STAGES < 1) ? 1 : ((STAGES > TABLE_LEN) ? TABLE_LEN : STAGES);

    logic signed [33:0] x_reg [1:N];
    logic signed [33:0] y_reg [1:N];
    logic signed [33:0] z_reg [1:N];
    logic               flip_reg [1:N];
    logic               v_reg [1:N];
    logic [SIDE_W-1:0]  side_reg [1:N];

    logic signed [16:0] t0;
    logic signed [16:0] t_adj;
    logic               flip0;

    always_comb
    begin
        t0 = {angle[15], angle};
        flip0 = 1'b0;
        t_adj = t0;
        if (t0 > 17'sd16384)
        begin
            t_adj = t0 - 17'sd32768;
            flip0 = 1'b1;
        end
        else if (t0 < -17'sd16384)
        begin
            t_adj = t0 + 17'sd32768;
            flip0 = 1'b1;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [33:0] xi;
        logic signed [33:0] yi;
        logic signed [33:0] zi;
        logic               fi;
        logic               vi;
        logic [SIDE_W-1:0]  si;

        if (i == 0)
        begin : g_first
            assign xi = 34'(CORDIC_GAIN);
            assign yi = '0;
            assign zi = {t_adj[16], t_adj, 16'd0};
            assign fi = flip0;
            assign vi = in_valid;
            assign si = side_in;
        end
        else
        begin : g_next
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
            assign fi = flip_reg[i];
            assign vi = v_reg[i];
            assign si = side_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= vi;
        end

        always_ff @(posedge clk)
        begin
            flip_reg[i+1] <= fi;
            side_reg[i+1] <= si;
            if (zi >= 0)
            begin
                x_reg[i+1] <= xi - (yi >>> i);
                y_reg[i+1] <= yi + (xi >>> i);
                z_reg[i+1] <= zi - 34'(atan_turn(i));
            end
            else
            begin
                x_reg[i+1] <= xi + (yi >>> i);
                y_reg[i+1] <= yi - (xi >>> i);
                z_reg[i+1] <= zi + 34'(atan_turn(i));
            end
        end
    end

    function automatic logic signed [31:0] clampq(input logic signed [33:0] v);
        begin
            if (v > 34'(Q30_ONE))
                return Q30_ONE;
            else if (v < -34'(Q30_ONE))
                return -Q30_ONE;
            else
                return v[31:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        side_out <= side_reg[N];
        cos_q30 <= clampq(flip_reg[N] ? -x_reg[N] : x_reg[N]);
        sin_q30 <= clampq(flip_reg[N] ? -y_reg[N] : y_reg[N]);
    end

endmodule

[hdl/wdpc_sensor.sv]
// Per-sensor front end: wall pick (comb), then registered offset rotation and range scale.
// Outputs are registered. Feeds the error CORDIC and finishes after it in the top.
module wdpc_sensor (
    input  logic               clk,
    input  logic [15:0]        angle,
    input  logic [12:0]        tol,
    input  logic               enabled,
    input  logic [13:0]        range_mm,
    input  logic signed [13:0] mx,
    input  logic signed [14:0] my,
    input  logic signed [31:0] ch,
    input  logic signed [31:0] sh,
    output logic               hit,
    output logic [1:0]         wall,
    output logic [15:0]        err,
    output logic signed [15:0] ox,
    output logic signed [15:0] oy,
    output logic [17:0]        range_r
);
    logic        hit_c;
    logic [1:0]  wall_c;
    logic [15:0] err_c;
    logic [15:0] d;
    logic [15:0] e;
    logic signed [46:0] pxc;
    logic signed [46:0] pxs;
    logic signed [46:0] pyc;
    logic signed [46:0] pys;
    logic signed [47:0] sx;
    logic signed [47:0] sy;
    logic [27:0] rn;
    logic [52:0] rq;

    always_comb
    begin
        hit_c = 1'b0;
        wall_c = '0;
        err_c = '0;
        for (int k = 3; k >= 0; k--)
        begin
            d = 16'(k * 16384) - angle;
            e = d[15] ? 16'(-d) : d;
            if (enabled && ({1'b0, e} < {4'd0, tol}) && !(d == 16'h8000))
            begin
                hit_c = 1'b1;
                wall_c = 2'(k);
                err_c = e;
            end
        end
        pxc = mx * ch;
        pxs = mx * sh;
        pyc = my * ch;
        pys = my * sh;
        sx = 48'(pxc) - 48'(pys) + 48'sd536870912;
        sy = 48'(pxs) + 48'(pyc) + 48'sd536870912;
        // dist*1280/127 rounded; divide by 127 as multiply by ceil(2^33/127)
        rn = 28'(range_mm) * 28'd1280 + 28'd63;
        rq = 53'(rn) * 53'd67637281;
    end

    always_ff @(posedge clk)
    begin
        hit <= hit_c;
        wall <= wall_c;
        err <= err_c;
        ox <= sx[45:30];
        oy <= sy[45:30];
        range_r <= rq[50:33];
    end

endmodule

[hdl/wall_distance_pose_correct_unit.sv]
// channel | signals                          | handshake
// in      | start, busy, in_word             | accepted when start && !busy
// out     | out_strobe, out_word             | one-cycle strobe, no stall
// cfg     | cfg_we, cfg_index, cfg_data      | written when cfg_we high
// One word per cycle. The path is the heading CORDIC pipeline (stages clamped to
// 1..24), the sensor stage and the wall error CORDIC pipeline in series, then
// four finishing stages.
// busy is always low; the output cannot be stalled.
// Reset clears valid bits and loads register defaults.
module wall_distance_pose_correct_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  wdpc_pkg::in_word_t   in_word,
    output logic                 out_strobe,
    output wdpc_pkg::out_word_t  out_word,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [14:0]          cfg_data
);
    import wdpc_pkg::*;

    localparam int IW = $bits(in_word_t);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_half_size <= 15'd18432;
            cfg_reg.wall_tol <= 13'd2731;
            cfg_reg.left_lateral_offset <= -14'sd1459;
            cfg_reg.right_lateral_offset <= 14'sd1152;
            cfg_reg.front_forward_offset <= 14'sd1664;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIELD: cfg_reg.field_half_size <= cfg_data;
                REG_TOL:   cfg_reg.wall_tol <= cfg_data[12:0];
                REG_LEFT:  cfg_reg.left_lateral_offset <= cfg_data[13:0];
                REG_RIGHT: cfg_reg.right_lateral_offset <= cfg_data[13:0];
                REG_FRONT: cfg_reg.front_forward_offset <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // heading CORDIC
    logic               h_valid;
    logic signed [31:0] ch;
    logic signed [31:0] sh;
    in_word_t           h_word;

    wdpc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(IW)) u_head (
        .clk(clk), .rst_n(rst_n),
        .in_valid(start), .angle(in_word.heading_turn), .side_in(in_word),
        .out_valid(h_valid), .cos_q30(ch), .sin_q30(sh), .side_out(h_word)
    );

    // three sensor front ends
    logic [2:0]         s_hit;
    logic [1:0]         s_wall [3];
    logic [15:0]        s_err [3];
    logic signed [15:0] s_ox [3];
    logic signed [15:0] s_oy [3];
    logic [17:0]        s_r [3];
    logic [15:0]        s_ang [3];
    logic [13:0]        s_dist [3];
    logic signed [13:0] s_mx [3];
    logic signed [14:0] s_my [3];

    always_comb
    begin
        s_ang[0] = h_word.heading_turn + 16'd16384;
        s_ang[1] = h_word.heading_turn + 16'd49152;
        s_ang[2] = h_word.heading_turn;
        s_dist[0] = h_word.dist_left;
        s_dist[1] = h_word.dist_right;
        s_dist[2] = h_word.dist_front;
        s_mx[0] = '0;
        s_mx[1] = '0;
        s_mx[2] = cfg_reg.front_forward_offset;
        // one bit wider so the most negative offset negates cleanly
        s_my[0] = -15'(cfg_reg.left_lateral_offset);
        s_my[1] = -15'(cfg_reg.right_lateral_offset);
        s_my[2] = '0;
    end

    for (genvar s = 0; s < 3; s++)
    begin : g_sen
        wdpc_sensor u_sen (
            .clk(clk), .angle(s_ang[s]), .tol(cfg_reg.wall_tol),
            .enabled(h_word.use_mask[s]), .range_mm(s_dist[s]), .mx(s_mx[s]),
            .my(s_my[s]),
            .ch(ch), .sh(sh), .hit(s_hit[s]), .wall(s_wall[s]), .err(s_err[s]),
            .ox(s_ox[s]), .oy(s_oy[s]), .range_r(s_r[s])
        );
    end

    logic     p1_valid_reg;
    in_word_t p1_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= h_valid;
    end

    always_ff @(posedge clk)
    begin
        p1_word_reg <= h_word;
    end

    // error CORDICs, sideband carries per-sensor terms
    localparam int SW = 1 + 2 + 16 + 16 + 18;
    logic [2:0]         e_valid;
    logic signed [31:0] ce [3];
    logic [SW-1:0]      e_side [3];

    for (genvar s = 0; s < 3; s++)
    begin : g_err
        wdpc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SW)) u_err (
            .clk(clk), .rst_n(rst_n), .in_valid(p1_valid_reg), .angle(s_err[s]),
            .side_in({s_hit[s], s_wall[s], s_ox[s], s_oy[s], s_r[s]}),
            .out_valid(e_valid[s]), .cos_q30(ce[s]), .sin_q30(),
            .side_out(e_side[s])
        );
    end

    // main word delay matched to error CORDIC latency
    in_word_t q_word;

    wdpc_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(IW)) u_dly (
        .clk(clk), .rst_n(rst_n), .in_valid(p1_valid_reg), .angle(16'd0),
        .side_in(p1_word_reg), .out_valid(), .cos_q30(), .sin_q30(),
        .side_out(q_word)
    );

    // stage A: R*cos(err) and wall coordinate per sensor
    logic signed [19:0] c_reg [3];
    logic [2:0]         cx_reg;
    logic [2:0]         cy_reg;
    logic               a_valid_reg;
    in_word_t           a_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= e_valid[0];
    end

    always_ff @(posedge clk)
    begin
        a_word_reg <= q_word;
        for (int s = 0; s < 3; s++)
        begin
            logic               h;
            logic [1:0]         w;
            logic signed [15:0] ox;
            logic signed [15:0] oy;
            logic [17:0]        r;
            logic signed [51:0] p;
            logic signed [19:0] rc;
            logic signed [19:0] f;
            {h, w, ox, oy, r} = e_side[s];
            p = $signed({1'b0, r}) * ce[s] + 52'sd536870912;
            rc = p[49:30];
            f = 20'(cfg_reg.field_half_size);
            unique case (w)
                2'd0: c_reg[s] <= f - rc - 20'(ox);
                2'd1: c_reg[s] <= f - rc - 20'(oy);
                2'd2: c_reg[s] <= rc - f - 20'(ox);
                default: c_reg[s] <= rc - f - 20'(oy);
            endcase
            cx_reg[s] <= h && !w[0];
            cy_reg[s] <= h && w[0];
        end
    end

    // stage B: sums and counts
    logic signed [21:0] sx_reg;
    logic signed [21:0] sy_reg;
    logic [1:0]         nx_reg;
    logic [1:0]         ny_reg;
    logic               b_valid_reg;
    in_word_t           b_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [21:0] ax;
        logic signed [21:0] ay;
        ax = '0;
        ay = '0;
        for (int s = 0; s < 3; s++)
        begin
            if (cx_reg[s]) ax = ax + 22'(c_reg[s]);
            if (cy_reg[s]) ay = ay + 22'(c_reg[s]);
        end
        sx_reg <= ax;
        sy_reg <= ay;
        nx_reg <= 2'($countones(cx_reg));
        ny_reg <= 2'($countones(cy_reg));
        b_word_reg <= a_word_reg;
    end

    // stage C: averages (divide by 3 via reciprocal multiply) and offsets from the reference
    function automatic logic signed [21:0] avg(input logic signed [21:0] s,
                                               input logic [1:0] n,
                                               input logic signed [15:0] dflt);
        logic [21:0] a;
        logic [21:0] q;
        logic [45:0] m;
        begin
            a = s[21] ? 22'(-s) : s;
            unique case (n)
                2'd0: q = '0;
                2'd1: q = a;
                2'd2: q = (a + 22'd1) >> 1;
                default:
                begin
                    m = 46'(a + 22'd1) * 46'd11184811;
                    q = 22'(m[45:25]);
                end
            endcase
            if (n == 2'd0)
                return 22'(dflt);
            else
                return s[21] ? 22'(-q) : q;
        end
    endfunction

    logic signed [21:0] x_reg;
    logic signed [21:0] y_reg;
    logic signed [21:0] dx_reg;
    logic signed [21:0] dy_reg;
    logic               c_valid_reg;
    in_word_t           c_word_reg;
    logic [1:0]         cnx_reg;
    logic [1:0]         cny_reg;
    logic signed [15:0] rx_reg;
    logic signed [15:0] ry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [21:0] xa;
        logic signed [21:0] ya;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        xa = avg(sx_reg, nx_reg, b_word_reg.est_x);
        ya = avg(sy_reg, ny_reg, b_word_reg.est_y);
        rx = b_word_reg.ref_valid[0] ? b_word_reg.ref_x : b_word_reg.est_x;
        ry = b_word_reg.ref_valid[1] ? b_word_reg.ref_y : b_word_reg.est_y;
        x_reg <= xa;
        y_reg <= ya;
        dx_reg <= xa - 22'(rx);
        dy_reg <= ya - 22'(ry);
        rx_reg <= rx;
        ry_reg <= ry;
        cnx_reg <= nx_reg;
        cny_reg <= ny_reg;
        c_word_reg <= b_word_reg;
    end

    // stage D: radius test and saturation
    function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
        begin
            if (v > 22'sd32767)
                return 16'sd32767;
            else if (v < -22'sd32768)
                return -16'sd32768;
            else
                return v[15:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_strobe <= 1'b0;
        else
            out_strobe <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [43:0] d2;
        logic [29:0] r2;
        logic        fb;
        d2 = 44'(44'(dx_reg) * 44'(dx_reg)) + 44'(44'(dy_reg) * 44'(dy_reg));
        r2 = c_word_reg.accept_radius * c_word_reg.accept_radius;
        fb = (c_word_reg.accept_radius == 15'd0) || (d2 > 44'(r2));
        out_word.pose_x <= fb ? rx_reg : sat16(x_reg);
        out_word.pose_y <= fb ? ry_reg : sat16(y_reg);
        out_word.heading_out <= c_word_reg.heading_passthru;
        out_word.x_hits <= cnx_reg;
        out_word.y_hits <= cny_reg;
        out_word.fell_back <= fb;
    end

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> (out_word.x_hits + out_word.y_hits) <= 3)
        else $error("hit count above sensor count");
    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_word_reg.accept_radius == 15'd0) |=> out_word.fell_back)
        else $error("zero radius did not fall back");

endmodule
